// ----- hw/rtl/row_gray_centroid_assert.svh -----
// ----------------------------------------------------------------------------
// Row gray centroid assertion macros
// Shared property forms for the checker of the row centroid block.
// ----------------------------------------------------------------------------
`ifndef ROW_GRAY_CENTROID_ASSERT_SVH
`define ROW_GRAY_CENTROID_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define RGC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("row_gray_centroid: property failed");

// Next-cycle implication, ignored while reset is asserted.
`define RGC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("row_gray_centroid: property failed");

// Next-cycle implication that also holds across reset.
`define RGC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("row_gray_centroid: property failed");

`endif

// ----- hw/rtl/rgc_pkg.sv -----
// ----------------------------------------------------------------------------
// Row gray centroid package
// Sizes, limits and the row job passed from the accumulator to the divider.
// ----------------------------------------------------------------------------
package rgc_pkg;

    localparam int MAX_COLS  = 4096;
    localparam int MAX_ROWS  = 4096;
    localparam int FRAC_BITS = 8;

    localparam int PIX_W    = 8;
    localparam int COUNT_W  = 12;
    localparam int WEIGHT_W = 20;
    localparam int MOMENT_W = 32;
    localparam int X_W      = 20;

    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam int COL_LIMIT = (MAX_COLS - 1 > COUNT_MAX) ? COUNT_MAX : MAX_COLS - 1;
    localparam int ROW_LIMIT = (MAX_ROWS - 1 > COUNT_MAX) ? COUNT_MAX : MAX_ROWS - 1;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd30;

    // Dividend is (moment << FRAC_BITS) plus half the weight, one spare bit for the carry.
    localparam int DVD_W  = MOMENT_W + FRAC_BITS + 1;
    localparam int STEP_W = $clog2(DVD_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [MOMENT_W-1:0] moment;
        logic [WEIGHT_W-1:0] weight;
        logic [COUNT_W-1:0]  row;
    } row_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- hw/rtl/rgc_front.sv -----
// ----------------------------------------------------------------------------
// Row gray centroid front end
// Takes pixels, keeps column and row counters and the per-row sums, and
// hands a finished row to the job queue.
// ----------------------------------------------------------------------------
module rgc_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [rgc_pkg::PIX_W-1:0]  cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [rgc_pkg::PIX_W-1:0]  s_pixel,
    input  logic                       s_row_end,
    input  logic                       s_frame_end,
    input  rgc_pkg::queue_status_t     q_status,
    output logic                       push,
    output rgc_pkg::row_job_t          push_job
);

    logic [rgc_pkg::PIX_W-1:0]    threshold_reg;
    logic [rgc_pkg::COUNT_W-1:0]  column_reg, column_next;
    logic [rgc_pkg::COUNT_W-1:0]  row_reg, row_next;
    logic [rgc_pkg::WEIGHT_W-1:0] weight_reg, weight_next;
    logic [rgc_pkg::MOMENT_W-1:0] moment_reg, moment_next;

    logic                                              accept;
    logic                                              above;
    logic                                              last;
    logic [rgc_pkg::WEIGHT_W:0]                        weight_sum;
    logic [rgc_pkg::PIX_W+rgc_pkg::COUNT_W-1:0]        product;
    logic [rgc_pkg::MOMENT_W:0]                        moment_sum;
    logic [rgc_pkg::WEIGHT_W-1:0]                      weight_upd;
    logic [rgc_pkg::MOMENT_W-1:0]                      moment_upd;

    // A full queue holds back every word, so a row end never finds it full.
    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign above   = s_pixel > threshold_reg;
    assign last    = s_row_end || s_frame_end;

    assign weight_sum = {1'b0, weight_reg} + (rgc_pkg::WEIGHT_W+1)'(s_pixel);
    assign product    = s_pixel * column_reg;
    assign moment_sum = {1'b0, moment_reg} + (rgc_pkg::MOMENT_W+1)'(product);

    always_comb begin
        weight_upd = weight_reg;
        moment_upd = moment_reg;
        if (above) begin
            weight_upd = weight_sum[rgc_pkg::WEIGHT_W] ? '1 : weight_sum[rgc_pkg::WEIGHT_W-1:0];
            moment_upd = moment_sum[rgc_pkg::MOMENT_W] ? '1 : moment_sum[rgc_pkg::MOMENT_W-1:0];
        end
    end

    assign push            = accept && last;
    assign push_job.moment = moment_upd;
    assign push_job.weight = weight_upd;
    assign push_job.row    = row_reg;

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        weight_next = weight_reg;
        moment_next = moment_reg;
        if (accept) begin
            if (last) begin
                column_next = '0;
                weight_next = '0;
                moment_next = '0;
                if (s_frame_end) begin
                    row_next = '0;
                end else if (row_reg < rgc_pkg::COUNT_W'(rgc_pkg::ROW_LIMIT)) begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                weight_next = weight_upd;
                moment_next = moment_upd;
                if (column_reg < rgc_pkg::COUNT_W'(rgc_pkg::COL_LIMIT)) begin
                    column_next = column_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= rgc_pkg::THRESHOLD_RESET;
            column_reg    <= '0;
            row_reg       <= '0;
            weight_reg    <= '0;
            moment_reg    <= '0;
        end else begin
            if (cfg_we) begin
                threshold_reg <= cfg_wdata;
            end
            column_reg <= column_next;
            row_reg    <= row_next;
            weight_reg <= weight_next;
            moment_reg <= moment_next;
        end
    end

endmodule

// ----- hw/rtl/rgc_queue.sv -----
// ----------------------------------------------------------------------------
// Row gray centroid job queue
// Small register FIFO of finished rows between front end and divider.
// ----------------------------------------------------------------------------
module rgc_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  rgc_pkg::row_job_t      push_job,
    input  logic                   pop,
    output rgc_pkg::row_job_t      head_job,
    output rgc_pkg::queue_status_t status
);

    rgc_pkg::row_job_t          entry_reg [rgc_pkg::QUEUE_DEPTH];
    logic [rgc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rgc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rgc_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push;
    logic                       do_pop;

    assign status.full  = count_reg == rgc_pkg::QCNT_W'(rgc_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == rgc_pkg::QPTR_W'(rgc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == rgc_pkg::QPTR_W'(rgc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hw/rtl/rgc_back.sv -----
// ----------------------------------------------------------------------------
// Row gray centroid back end
// Restoring divider, one quotient bit per cycle, and the result register.
// ----------------------------------------------------------------------------
module rgc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rgc_pkg::queue_status_t        q_status,
    input  rgc_pkg::row_job_t             head_job,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rgc_pkg::X_W-1:0]       m_centroid_x,
    output logic [rgc_pkg::COUNT_W-1:0]   m_row_index,
    output logic                          m_row_empty
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t                   state_reg, state_next;
    logic [rgc_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [rgc_pkg::DVD_W-1:0]     dvd_reg, dvd_next;
    logic [rgc_pkg::WEIGHT_W-1:0]  rem_reg, rem_next;
    logic [rgc_pkg::WEIGHT_W-1:0]  weight_reg, weight_next;
    logic [rgc_pkg::COUNT_W-1:0]   row_reg, row_next;

    logic                          out_valid_reg, out_valid_next;
    logic [rgc_pkg::X_W-1:0]       out_x_reg, out_x_next;
    logic [rgc_pkg::COUNT_W-1:0]   out_row_reg, out_row_next;
    logic                          out_empty_reg, out_empty_next;

    logic [rgc_pkg::WEIGHT_W:0]    rem_shift;
    logic                          q_bit;
    logic [rgc_pkg::DVD_W-1:0]     dividend;
    logic                          load_out;
    logic                          row_is_empty;
    logic [rgc_pkg::X_W-1:0]       quotient_sat;

    assign dividend = (rgc_pkg::DVD_W'(head_job.moment) << rgc_pkg::FRAC_BITS)
                    + rgc_pkg::DVD_W'(head_job.weight >> 1);

    assign rem_shift = {rem_reg, dvd_reg[rgc_pkg::DVD_W-1]};
    assign q_bit     = rem_shift >= {1'b0, weight_reg};

    assign row_is_empty = weight_reg == '0;
    assign quotient_sat = (|dvd_reg[rgc_pkg::DVD_W-1:rgc_pkg::X_W])
                        ? '1 : dvd_reg[rgc_pkg::X_W-1:0];

    // The result register frees up in the same cycle its word is taken.
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);
    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        weight_next = weight_reg;
        row_next    = row_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    dvd_next    = dividend;
                    rem_next    = '0;
                    weight_next = head_job.weight;
                    row_next    = head_job.row;
                    step_next   = '0;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = q_bit ? rem_shift[rgc_pkg::WEIGHT_W-1:0] - weight_reg
                                  : rem_shift[rgc_pkg::WEIGHT_W-1:0];
                dvd_next  = {dvd_reg[rgc_pkg::DVD_W-2:0], q_bit};
                step_next = step_reg + 1'b1;
                if (step_reg == rgc_pkg::STEP_W'(rgc_pkg::DVD_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_x_next     = out_x_reg;
        out_row_next   = out_row_reg;
        out_empty_next = out_empty_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_x_next     = row_is_empty ? '0 : quotient_sat;
            out_row_next   = row_reg;
            out_empty_next = row_is_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        weight_reg    <= weight_next;
        row_reg       <= row_next;
        out_x_reg     <= out_x_next;
        out_row_reg   <= out_row_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_centroid_x = out_x_reg;
    assign m_row_index  = out_row_reg;
    assign m_row_empty  = out_empty_reg;

endmodule

// ----- hw/rtl/row_gray_centroid.sv -----
// ----------------------------------------------------------------------------
// Row gray centroid
// Gray-centroid laser stripe centre: one weighted column centroid per row.
// ----------------------------------------------------------------------------
// Pixels are taken at one word per clock while the row job queue (two rows
// deep) has room. Each row end hands the row's sums to a restoring divider
// that produces one quotient bit per cycle over 41 divide steps, then loads
// the result register; rows long enough to cover the divide stream at one
// pixel per clock while results are taken, shorter rows stall the input once
// the queue fills. The centroid carries eight fraction bits, rounded to
// nearest, and an empty row reports zero with its flag set.
module row_gray_centroid (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [rgc_pkg::PIX_W-1:0]    cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rgc_pkg::PIX_W-1:0]    s_pixel,
    input  logic                         s_row_end,
    input  logic                         s_frame_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rgc_pkg::X_W-1:0]      m_centroid_x,
    output logic [rgc_pkg::COUNT_W-1:0]  m_row_index,
    output logic                         m_row_empty
);

    rgc_pkg::queue_status_t q_status;
    rgc_pkg::row_job_t      push_job;
    rgc_pkg::row_job_t      head_job;
    logic                   push;
    logic                   pop;

    rgc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .s_row_end   (s_row_end),
        .s_frame_end (s_frame_end),
        .q_status    (q_status),
        .push        (push),
        .push_job    (push_job)
    );

    rgc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    rgc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .head_job     (head_job),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_centroid_x (m_centroid_x),
        .m_row_index  (m_row_index),
        .m_row_empty  (m_row_empty)
    );

endmodule

// ----- hw/rtl/rgc_checker.sv -----
// ----------------------------------------------------------------------------
// Row gray centroid checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "row_gray_centroid_assert.svh"

module rgc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [rgc_pkg::X_W-1:0]      m_centroid_x,
    input logic [rgc_pkg::COUNT_W-1:0]  m_row_index,
    input logic                         m_row_empty
);

    logic [rgc_pkg::X_W+rgc_pkg::COUNT_W:0] m_word;

    assign m_word = {m_centroid_x, m_row_index, m_row_empty};

    // An empty row always reports a zero centroid.
    `RGC_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_valid && m_row_empty, m_centroid_x == '0)

    // No result word is left over from before reset.
    `RGC_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_valid)

    `RGC_ASSERT_NEXT(a_valid_holds, aclk, aresetn, m_valid && !m_ready, m_valid)

    `RGC_ASSERT_NEXT(a_word_holds, aclk, aresetn, m_valid && !m_ready, $stable(m_word))

endmodule

bind row_gray_centroid rgc_checker u_rgc_checker (.*);
